// ===== src/tts_pkg.sv =====
// Package: fixed-point constants and arithmetic helpers for the tridiagonal solver.
package tts_pkg;

  localparam int MaxPoints = 64;
  localparam int FracBits  = 16;
  localparam int IdxW      = $clog2(MaxPoints);
  localparam int CntW      = IdxW + 1;
  localparam int DataW     = 32;

  typedef logic signed [DataW-1:0] word_t;

  typedef enum logic {
    CFG_LEFT_COUPLING  = 1'b0,
    CFG_RIGHT_COUPLING = 1'b1
  } cfg_reg_t;

  localparam logic signed [DataW-1:0] WordMax = {1'b0, {(DataW-1){1'b1}}};
  localparam logic signed [DataW-1:0] WordMin = {1'b1, {(DataW-1){1'b0}}};

  // floor(product / 2^FracBits), arithmetic shift is floor
  function automatic logic signed [2*DataW-1:0] scale_prod(logic signed [2*DataW-1:0] p);
    scale_prod = p >>> FracBits;
  endfunction

  function automatic logic sat_hit(logic signed [2*DataW+1:0] v);
    sat_hit = (v > 66'(signed'(WordMax))) || (v < 66'(signed'(WordMin)));
  endfunction

  function automatic word_t sat_word(logic signed [2*DataW+1:0] v);
    if (v > 66'(signed'(WordMax))) begin
      sat_word = WordMax;
    end else if (v < 66'(signed'(WordMin))) begin
      sat_word = WordMin;
    end else begin
      sat_word = v[DataW-1:0];
    end
  endfunction

endpackage

// ===== src/tts_stream_if.sv =====
// Interfaces: valid/ready channels for rows, results and configuration writes.
interface tts_row_if;
  logic                  valid;
  logic                  ready;
  tts_pkg::word_t        coef_sub;
  tts_pkg::word_t        coef_diag;
  tts_pkg::word_t        coef_super;
  tts_pkg::word_t        rhs;
  tts_pkg::word_t        left_value;
  tts_pkg::word_t        right_value;
  logic                  last_row;
  modport source (output valid, coef_sub, coef_diag, coef_super, rhs, left_value,
                  right_value, last_row, input ready);
  modport sink (input valid, coef_sub, coef_diag, coef_super, rhs, left_value,
                right_value, last_row, output ready);
endinterface

interface tts_res_if;
  logic                        valid;
  logic                        ready;
  tts_pkg::word_t              value;
  logic [tts_pkg::IdxW-1:0]    index;
  logic                        error_flag;
  logic                        last_result;
  modport source (output valid, value, index, error_flag, last_result, input ready);
  modport sink (input valid, value, index, error_flag, last_result, output ready);
endinterface

interface tts_cfg_if;
  logic           valid;
  logic           ready;
  logic [0:0]     index;
  tts_pkg::word_t data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== src/tridiagonal_thomas_solver.sv =====
// Top level: Thomas-algorithm tridiagonal solver with alpha/beta stores.
//
// Rows 1..n-1 of a system arrive on the in_ channel, one transaction each.
// The first row of a system also loads left_value, the row with last_row set
// brings right_value. Each row reads alpha/beta from two 64-entry RAMs, runs
// two serial divisions (alpha and beta) on the shared bit-serial divider and
// writes back; a zero denominator cuts a division short. After the last row,
// u[n] needs one more division; back substitution then emits u[n] down to
// u[0] on the out_ channel, each with its index, and computes the next
// unknown only after the receiver has taken the last one; last_result marks
// u[0]. error_flag is sticky per system.
// When the receiver stalls, the held result stays on out_ and the block waits.
// No new row is taken until the whole solution has been delivered.
// cfg_ writes set left_coupling (index 0) and right_coupling (index 1); they
// are always accepted. Reset clears the couplings, row count and error flag;
// the RAMs are not cleared: every entry is written before its value is used.
module tridiagonal_thomas_solver (
  input logic clk,
  input logic rst_n,
  tts_row_if.sink   in,
  tts_res_if.source out,
  tts_cfg_if.sink   cfg
);
  localparam int IW = tts_pkg::IdxW;
  localparam int W  = tts_pkg::DataW;
  typedef logic signed [2*W+1:0] wide_t;

  typedef enum logic [3:0] {
    S_IDLE, S_RD, S_MUL, S_DEN, S_DIVA, S_DIVB, S_WR,
    S_BRD, S_BMUL, S_BDEN, S_BDIV, S_SRD, S_SMUL, S_SSUM, S_OUT
  } state_t;

  state_t state_r;
  tts_pkg::word_t lc_r, rc_r;
  logic [tts_pkg::CntW-1:0] row_count_r;
  logic sticky_r;
  tts_pkg::word_t a_r, c_r, b_r, f_r, rv_r, lv_r, den_r, num_r, u_r, al_r;
  logic last_r;
  logic [IW-1:0] j_r, i_r;
  logic signed [2*W-1:0] p1_r, p2_r;

  logic           ram_we;
  logic [IW-1:0]  ram_waddr, ram_raddr;
  tts_pkg::word_t al_wdata, be_wdata, al_q, be_q;

  logic           div_start, div_done, div_err;
  tts_pkg::word_t div_num, div_den, div_q;

  tts_ram #(.Width(W), .Depth(tts_pkg::MaxPoints)) u_alpha (
    .clk, .we(ram_we), .waddr(ram_waddr), .wdata(al_wdata), .raddr(ram_raddr), .rdata(al_q));
  tts_ram #(.Width(W), .Depth(tts_pkg::MaxPoints)) u_beta (
    .clk, .we(ram_we), .waddr(ram_waddr), .wdata(be_wdata), .raddr(ram_raddr), .rdata(be_q));

  tts_div u_div (.clk, .rst_n, .start(div_start), .num(div_num), .den(div_den),
                 .done(div_done), .quo(div_q), .err(div_err));

  assign cfg.ready = 1'b1;
  assign in.ready  = (state_r == S_IDLE);

  wide_t den_w, num_w, negb_w, bn_w, bd_w, s_w;
  assign den_w  = wide_t'(c_r) + wide_t'(tts_pkg::scale_prod(p1_r));
  assign num_w  = wide_t'(f_r) - wide_t'(tts_pkg::scale_prod(p2_r));
  assign negb_w = -wide_t'(b_r);
  assign bn_w   = wide_t'(rv_r) + wide_t'(tts_pkg::scale_prod(p2_r));
  assign bd_w   = (wide_t'(1) <<< tts_pkg::FracBits) - wide_t'(tts_pkg::scale_prod(p1_r));
  assign s_w    = wide_t'(tts_pkg::scale_prod(p1_r)) + wide_t'(be_q);

  always_comb begin
    ram_raddr = (state_r == S_IDLE || state_r == S_WR) ? i_r : j_r;
    ram_waddr = (state_r == S_RD) ? IW'(1) : IW'(i_r + 1'b1);
    ram_we    = 1'b0;
    al_wdata  = lc_r;
    be_wdata  = lv_r;
    if (state_r == S_RD && row_count_r == '0) begin
      ram_we = 1'b1;
    end else if (state_r == S_WR) begin
      ram_we   = 1'b1;
      al_wdata = al_r;
      be_wdata = div_q;
    end
    div_start = 1'b0;
    div_num   = num_r;
    div_den   = den_r;
    if (state_r == S_DEN || state_r == S_BDEN) begin
      div_start = 1'b1;
      div_num   = (state_r == S_DEN) ? tts_pkg::sat_word(negb_w) : tts_pkg::sat_word(bn_w);
      div_den   = (state_r == S_DEN) ? tts_pkg::sat_word(den_w) : tts_pkg::sat_word(bd_w);
    end else if (state_r == S_DIVA && div_done) begin
      div_start = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      lc_r        <= '0;
      rc_r        <= '0;
      row_count_r <= '0;
      sticky_r    <= 1'b0;
      out.valid   <= 1'b0;
      i_r         <= IW'(1);
    end else begin
      if (cfg.valid) begin
        unique case (tts_pkg::cfg_reg_t'(cfg.index))
          tts_pkg::CFG_LEFT_COUPLING:  lc_r <= cfg.data;
          tts_pkg::CFG_RIGHT_COUPLING: rc_r <= cfg.data;
          default: ;
        endcase
      end
      unique case (state_r)
        S_IDLE: begin
          if (in.valid) begin
            a_r    <= in.coef_sub;
            c_r    <= in.coef_diag;
            b_r    <= in.coef_super;
            f_r    <= in.rhs;
            lv_r   <= in.left_value;
            rv_r   <= in.right_value;
            last_r <= in.last_row;
            i_r    <= IW'(row_count_r + 1'b1);
            j_r    <= IW'(row_count_r + 1'b1);
            if (row_count_r == '0) begin
              sticky_r <= 1'b0;
            end
            state_r <= S_RD;
          end
        end
        S_RD: begin
          state_r <= S_MUL;
        end
        S_MUL: begin
          if (row_count_r == '0) begin
            p1_r <= lc_r * a_r;
            p2_r <= a_r * lv_r;
          end else begin
            p1_r <= al_q * a_r;
            p2_r <= a_r * be_q;
          end
          state_r <= S_DEN;
        end
        S_DEN: begin
          den_r <= tts_pkg::sat_word(den_w);
          num_r <= tts_pkg::sat_word(num_w);
          if (tts_pkg::sat_hit(den_w) || tts_pkg::sat_hit(num_w) || tts_pkg::sat_hit(negb_w)) begin
            sticky_r <= 1'b1;
          end
          state_r <= S_DIVA;
        end
        S_DIVA: begin
          if (div_done) begin
            al_r <= div_q;
            if (div_err) sticky_r <= 1'b1;
            state_r <= S_DIVB;
          end
        end
        S_DIVB: begin
          if (div_done) begin
            if (div_err) sticky_r <= 1'b1;
            state_r <= S_WR;
          end
        end
        S_WR: begin
          j_r <= IW'(i_r + 1'b1);
          if (!last_r && (32'(i_r) + 1 < tts_pkg::MaxPoints - 1)) begin
            row_count_r <= row_count_r + 1'b1;
            state_r     <= S_IDLE;
          end else begin
            state_r <= S_BRD;
          end
        end
        S_BRD: begin
          state_r <= S_BMUL;
        end
        S_BMUL: begin
          p1_r    <= al_q * rc_r;
          p2_r    <= be_q * rc_r;
          state_r <= S_BDEN;
        end
        S_BDEN: begin
          if (tts_pkg::sat_hit(bn_w) || tts_pkg::sat_hit(bd_w)) begin
            sticky_r <= 1'b1;
          end
          state_r <= S_BDIV;
        end
        S_BDIV: begin
          if (div_done) begin
            u_r <= div_q;
            if (div_err) sticky_r <= 1'b1;
            out.value       <= div_q;
            out.index       <= j_r;
            out.last_result <= 1'b0;
            out.error_flag  <= sticky_r | div_err;
            out.valid       <= 1'b1;
            state_r         <= S_OUT;
          end
        end
        S_OUT: begin
          if (out.ready) begin
            out.valid <= 1'b0;
            if (out.last_result) begin
              row_count_r <= '0;
              i_r         <= IW'(1);
              state_r     <= S_IDLE;
            end else begin
              state_r <= S_SRD;
            end
          end
        end
        S_SRD: begin
          state_r <= S_SMUL;
        end
        S_SMUL: begin
          p1_r    <= al_q * u_r;
          state_r <= S_SSUM;
        end
        S_SSUM: begin
          u_r             <= tts_pkg::sat_word(s_w);
          out.value       <= tts_pkg::sat_word(s_w);
          out.index       <= IW'(j_r - 1'b1);
          out.last_result <= (j_r == IW'(1));
          out.error_flag  <= sticky_r | tts_pkg::sat_hit(s_w);
          if (tts_pkg::sat_hit(s_w)) sticky_r <= 1'b1;
          j_r       <= IW'(j_r - 1'b1);
          out.valid <= 1'b1;
          state_r   <= S_OUT;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule

// ===== src/tts_ram.sv =====
// Generic single-port-write, registered-read RAM.
module tts_ram #(
  parameter int Width = 32,
  parameter int Depth = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== src/tts_div.sv =====
// Iterative signed Q-format divider: (num << FracBits) / den, truncated, saturated.
module tts_div (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  tts_pkg::word_t num,
  input  tts_pkg::word_t den,
  output logic           done,
  output tts_pkg::word_t quo,
  output logic           err
);
  localparam int NW = tts_pkg::DataW + tts_pkg::FracBits;
  localparam int StepW = $clog2(NW + 1);

  logic [NW-1:0]          rem_num_r;
  logic [tts_pkg::DataW:0] rem_r;
  logic [tts_pkg::DataW-1:0] dabs_r;
  logic [NW-1:0]          q_r;
  logic                   neg_r;
  logic                   busy_r;
  logic [StepW-1:0]       step_r;
  logic [tts_pkg::DataW:0] sh;
  logic [tts_pkg::DataW:0] diff;
  logic signed [2*tts_pkg::DataW+1:0] sq;
  logic [tts_pkg::DataW-1:0] nmag;
  logic [NW-1:0]          nabs;

  assign sh   = {rem_r[tts_pkg::DataW-1:0], rem_num_r[NW-1]};
  assign diff = sh - {1'b0, dabs_r};
  assign nmag = num[tts_pkg::DataW-1] ? -num : num;
  assign nabs = {nmag, {tts_pkg::FracBits{1'b0}}};

  always_comb begin
    sq = neg_r ? -(66'(q_r)) : 66'(q_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done   <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        if (den == '0) begin
          done <= 1'b1;
          quo  <= '0;
          err  <= 1'b1;
        end else begin
          busy_r    <= 1'b1;
          step_r    <= '0;
          rem_num_r <= nabs;
          rem_r     <= '0;
          q_r       <= '0;
          dabs_r    <= den[tts_pkg::DataW-1] ? -den : den;
          neg_r     <= num[tts_pkg::DataW-1] ^ den[tts_pkg::DataW-1];
        end
      end else if (busy_r) begin
        if (step_r == StepW'(NW)) begin
          busy_r <= 1'b0;
          done   <= 1'b1;
          quo    <= tts_pkg::sat_word(sq);
          err    <= tts_pkg::sat_hit(sq);
        end else begin
          step_r    <= step_r + 1'b1;
          rem_num_r <= rem_num_r << 1;
          if (!diff[tts_pkg::DataW]) begin
            rem_r <= diff;
            q_r   <= {q_r[NW-2:0], 1'b1};
          end else begin
            rem_r <= sh;
            q_r   <= {q_r[NW-2:0], 1'b0};
          end
        end
      end
    end
  end
endmodule

// ===== dv/tts_tb_pkg.sv =====
// Package: row and result types for the tridiagonal solver testbench.
package tts_tb_pkg;
  import tts_pkg::*;

  typedef struct packed {
    word_t coef_sub;
    word_t coef_diag;
    word_t coef_super;
    word_t rhs;
    word_t left_value;
    word_t right_value;
    logic  last_row;
  } row_t;

  typedef struct packed {
    word_t            value;
    logic [IdxW-1:0]  index;
    logic             error_flag;
    logic             last_result;
  } unknown_t;
endpackage

// ===== dv/testbench.sv =====
// Testbench: random and directed tridiagonal systems checked against a Thomas sweep predictor.
module testbench;
  import tts_pkg::*;
  import tts_tb_pkg::*;

  localparam int StallLimit = 20000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  tts_row_if row_ch ();
  tts_res_if res_ch ();
  tts_cfg_if cfg_ch ();

  tridiagonal_thomas_solver dut (
    .clk(clk), .rst_n(rst_n), .in(row_ch.sink), .out(res_ch.source), .cfg(cfg_ch.sink)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  row_t     pending_rows[$];
  unknown_t solution_q[$];
  int       fail_count = 0;
  bit       calm = 1'b0;
  int       hold_off = 0;
  int       sender_gap = 0;
  int       receiver_gap = 0;
  int       idle_cycles = 0;

  word_t coupling_l = '0;
  word_t coupling_r = '0;
  word_t alpha_mem[MaxPoints];
  word_t beta_mem[MaxPoints];
  int    rows_taken = 0;
  bit    err_sticky = 1'b0;

  function automatic word_t clip(longint v);
    if (v > longint'(WordMax)) begin
      err_sticky = 1'b1;
      return WordMax;
    end
    if (v < longint'(WordMin)) begin
      err_sticky = 1'b1;
      return WordMin;
    end
    return word_t'(v);
  endfunction

  function automatic longint fx_mul(word_t x, word_t y);
    longint p;
    p = longint'(x) * longint'(y);
    return p >>> FracBits;
  endfunction

  function automatic word_t fx_div(word_t num, word_t den);
    logic signed [95:0] q;
    if (den == 0) begin
      err_sticky = 1'b1;
      return '0;
    end
    q = (96'(num) <<< FracBits) / 96'(den);
    if (q > 96'(WordMax)) begin
      err_sticky = 1'b1;
      return WordMax;
    end
    if (q < 96'(WordMin)) begin
      err_sticky = 1'b1;
      return WordMin;
    end
    return word_t'(q);
  endfunction

  task automatic sweep_row(row_t r);
    int i, n;
    word_t den, num, u;
    if (rows_taken > MaxPoints - 3) rows_taken = 0;
    if (rows_taken == 0) begin
      err_sticky = 1'b0;
      alpha_mem[1] = coupling_l;
      beta_mem[1] = r.left_value;
    end
    i = rows_taken + 1;
    den = clip(longint'(r.coef_diag) + fx_mul(alpha_mem[i], r.coef_sub));
    alpha_mem[i+1] = fx_div(clip(-longint'(r.coef_super)), den);
    num = clip(longint'(r.rhs) - fx_mul(r.coef_sub, beta_mem[i]));
    beta_mem[i+1] = fx_div(num, den);
    if (!r.last_row && i + 1 < MaxPoints - 1) begin
      rows_taken++;
      return;
    end
    n = i + 1;
    num = clip(longint'(r.right_value) + fx_mul(beta_mem[n], coupling_r));
    den = clip((longint'(1) <<< FracBits) - fx_mul(alpha_mem[n], coupling_r));
    u = fx_div(num, den);
    solution_q.push_back('{u, IdxW'(n), err_sticky, 1'b0});
    for (int j = n; j > 0; j--) begin
      u = clip(fx_mul(alpha_mem[j], u) + longint'(beta_mem[j]));
      solution_q.push_back('{u, IdxW'(j - 1), err_sticky, j == 1});
    end
    rows_taken = 0;
  endtask

  function automatic word_t rand_word();
    case ($urandom_range(0, 5))
      0: return WordMax;
      1: return WordMin;
      2: return word_t'($urandom);
      default: return word_t'($signed($urandom_range(0, 32'h6_0000)) - 32'sh3_0000);
    endcase
  endfunction

  function automatic row_t rand_row(bit fin);
    row_t r;
    r.coef_sub = rand_word();
    r.coef_diag = ($urandom_range(0, 9) == 0) ? rand_word()
                : word_t'(32'sh4_0000 + $urandom_range(0, 32'h4_0000));
    r.coef_super = rand_word();
    r.rhs = rand_word();
    r.left_value = rand_word();
    r.right_value = rand_word();
    r.last_row = fin;
    return r;
  endfunction

  task automatic queue_system(int rows);
    for (int k = 0; k < rows; k++) pending_rows.push_back(rand_row(k == rows - 1));
  endtask

  task automatic wait_drained();
    while (pending_rows.size() != 0 || row_ch.valid || solution_q.size() != 0)
      @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, word_t val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    if (idx == CFG_LEFT_COUPLING) coupling_l = val;
    else coupling_r = val;
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      row_ch.valid <= 1'b0;
    end else begin
      if (row_ch.valid && row_ch.ready) sweep_row(pending_rows.pop_front());
      if (row_ch.valid && !row_ch.ready) begin
      end else if (sender_gap > 0) begin
        sender_gap <= sender_gap - 1;
        row_ch.valid <= 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        sender_gap <= $urandom_range(0, 3);
        row_ch.valid <= 1'b0;
      end else if (pending_rows.size() > (row_ch.valid && row_ch.ready ? 0 : 0)) begin
        row_ch.valid <= 1'b1;
        {row_ch.coef_sub, row_ch.coef_diag, row_ch.coef_super, row_ch.rhs,
         row_ch.left_value, row_ch.right_value, row_ch.last_row} <= pending_rows[0];
      end else begin
        row_ch.valid <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    unknown_t want;
    if (!rst_n) begin
      res_ch.ready <= 1'b0;
    end else begin
      if (res_ch.valid && res_ch.ready) begin
        if (solution_q.size() == 0) begin
          $error("unexpected transaction value=%0d index=%0d", res_ch.value, res_ch.index);
          fail_count++;
        end else begin
          want = solution_q.pop_front();
          if (res_ch.value !== want.value) begin
            $error("value expected %0d actual %0d", want.value, res_ch.value);
            fail_count++;
          end
          if (res_ch.index !== want.index) begin
            $error("index expected %0d actual %0d", want.index, res_ch.index);
            fail_count++;
          end
          if (res_ch.error_flag !== want.error_flag) begin
            $error("error_flag expected %0b actual %0b", want.error_flag, res_ch.error_flag);
            fail_count++;
          end
          if (res_ch.last_result !== want.last_result) begin
            $error("last_result expected %0b actual %0b", want.last_result,
                   res_ch.last_result);
            fail_count++;
          end
        end
      end
      if (hold_off > 0) begin
        hold_off <= hold_off - 1;
        res_ch.ready <= 1'b0;
      end else if (receiver_gap > 0) begin
        receiver_gap <= receiver_gap - 1;
        res_ch.ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        receiver_gap <= $urandom_range(0, 3);
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= 1'b1;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((row_ch.valid && row_ch.ready) || (res_ch.valid && res_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= StallLimit) begin
      $display("tridiagonal_thomas_solver: mismatch");
      $finish;
    end
  end

  initial begin
    row_t r;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = CFG_LEFT_COUPLING;
    cfg_ch.data = '0;
    row_ch.valid = 1'b0;
    {row_ch.coef_sub, row_ch.coef_diag, row_ch.coef_super, row_ch.rhs,
     row_ch.left_value, row_ch.right_value, row_ch.last_row} = '0;
    res_ch.ready = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // default couplings: smallest system, extremes, zero denominator
    r = '{32'sh1_0000, 32'sh2_0000, 32'sh1_0000, 32'sh1_0000, 32'sh8000, -32'sh8000, 1'b1};
    pending_rows.push_back(r);
    r = '{WordMax, WordMin, WordMax, WordMin, WordMax, WordMin, 1'b0};
    pending_rows.push_back(r);
    r = '{WordMin, WordMax, WordMin, WordMax, WordMin, WordMax, 1'b1};
    pending_rows.push_back(r);
    r = '{'0, '0, 32'sh1_0000, 32'sh1_0000, '0, 32'sh1_0000, 1'b1};
    pending_rows.push_back(r);
    r = '{-32'sh1, 32'sh3_0000, -32'sh1, -32'sh1, -32'sh1, -32'sh1, 1'b0};
    pending_rows.push_back(r);
    pending_rows.push_back(rand_row(1'b1));
    wait_drained();

    write_reg(CFG_LEFT_COUPLING, 32'sh8000);
    write_reg(CFG_RIGHT_COUPLING, -32'sh4000);
    // too many rows: last_row never set, block closes the system itself
    for (int k = 0; k < MaxPoints - 2; k++) pending_rows.push_back(rand_row(1'b0));
    queue_system(2);
    wait_drained();

    write_reg(CFG_RIGHT_COUPLING, 32'sh1_0000);
    write_reg(CFG_LEFT_COUPLING, WordMax);
    queue_system(3);
    wait_drained();
    write_reg(CFG_LEFT_COUPLING, WordMin);
    write_reg(CFG_RIGHT_COUPLING, WordMax);
    queue_system(2);
    wait_drained();
    write_reg(CFG_RIGHT_COUPLING, WordMin);
    queue_system(4);
    wait_drained();

    // long receiver hold-off while rows keep coming
    write_reg(CFG_LEFT_COUPLING, word_t'($urandom_range(0, 32'h1_0000)));
    write_reg(CFG_RIGHT_COUPLING, word_t'($urandom_range(0, 32'h1_0000)));
    hold_off = 3000;
    repeat (6) queue_system($urandom_range(1, 6));
    wait_drained();

    repeat (16) queue_system($urandom_range(1, 6));
    wait_drained();
    calm = 1'b1;
    repeat (5) queue_system($urandom_range(1, 6));
    wait_drained();
    repeat (200) @(posedge clk);

    if (fail_count == 0) begin
      $display("tridiagonal_thomas_solver: match");
    end else begin
      $display("tridiagonal_thomas_solver: mismatch");
    end
    $finish;
  end
endmodule
